FILE: design/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite camera projection package
// Shared widths, fixed-point constants, the arctangent table, register
// indexes and the structures passed between the pipeline cells.
// ----------------------------------------------------------------------------
package scp_pkg;

   // Angle width of the CORDIC datapaths, in Q24 radians.
   localparam int Z_W = 28;
   // Sprite vectoring datapath: 33-bit offset scaled by 2^8 plus CORDIC growth.
   localparam int VS_W = 44;
   // Camera vectoring datapath: 16-bit direction scaled by 2^16 plus growth.
   localparam int VC_W = 35;
   // Rotating (cosine) datapath, Q24 with headroom.
   localparam int R_W = 27;
   // Magnitude after gain correction and the combined shift by 24.
   localparam int MAG_W = VS_W + 15 - 24;
   // Product of magnitude and cosine, and the distance taken from it.
   localparam int PROD_W = MAG_W + 1 + R_W;
   localparam int DIST_W = PROD_W - 25;
   // Quotient width of every divider chain.
   localparam int Q_W = 16;

   localparam logic signed [Z_W-1:0] PI_Q24  = 52707179;
   localparam logic signed [Z_W-1:0] RND_Q24 = 1024;
   localparam logic signed [16:0] PI_Q13      = 25736;
   localparam logic signed [16:0] TWO_PI_Q13  = 51472;
   localparam logic signed [16:0] HALF_PI_Q13 = 12868;
   localparam logic [15:0] GAIN_Q16 = 16'd39797;
   localparam logic signed [R_W-1:0] GAIN_Q24 = 10187176;

   // Arctangent of 2^-i in Q24 radians.
   localparam logic signed [Z_W-1:0] ATAN_Q24 [0:23] = '{
      13176795, 7778716, 4110060, 2086331, 1047215, 524117, 262124, 131070,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_FOV    = 3'd0;
   localparam logic [2:0] CSR_PW     = 3'd1;
   localparam logic [2:0] CSR_PD     = 3'd2;
   localparam logic [2:0] CSR_CH     = 3'd3;
   localparam logic [2:0] CSR_SH     = 3'd4;

   // Sideband carried along the cosine chain.
   typedef struct packed {
      logic                    vis;
      logic                    neg;
      logic signed [15:0]      ang;
      logic [MAG_W-1:0]        mag;
   } rot_side_type;

   // One finished result.
   typedef struct packed {
      logic        visible;
      logic [15:0] scale;
      logic [15:0] anchor_y;
      logic [15:0] anchor_x;
   } rsp_type;

endpackage

FILE: design/scp_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation that drives y toward zero and accumulates the heading.
// ----------------------------------------------------------------------------
module scp_vec_cell
   import scp_pkg::*;
#(
   parameter int W     = 44,
   parameter int SHIFT = 0,
   parameter int SW    = 1
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   in_x,
   input  logic signed [W-1:0]   in_y,
   input  logic signed [Z_W-1:0] in_z,
   input  logic [SW-1:0]         in_side,
   output logic signed [W-1:0]   out_x,
   output logic signed [W-1:0]   out_y,
   output logic signed [Z_W-1:0] out_z,
   output logic [SW-1:0]         out_side
);

   logic signed [W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic [SW-1:0]         side_ff;

   // Rotate against the sign of y.
   always_comb begin
      if (in_y < 0) begin
         x_in = in_x - (in_y >>> SHIFT);
         y_in = in_y + (in_x >>> SHIFT);
         z_in = in_z - ATAN_Q24[SHIFT];
      end else begin
         x_in = in_x + (in_y >>> SHIFT);
         y_in = in_y - (in_x >>> SHIFT);
         z_in = in_z + ATAN_Q24[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule

FILE: design/scp_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating CORDIC cell
// One micro-rotation that drives the residual angle toward zero.
// ----------------------------------------------------------------------------
module scp_rot_cell
   import scp_pkg::*;
#(
   parameter int SHIFT = 0,
   parameter int SW    = 1
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [R_W-1:0] in_x,
   input  logic signed [R_W-1:0] in_y,
   input  logic signed [Z_W-1:0] in_z,
   input  logic [SW-1:0]         in_side,
   output logic signed [R_W-1:0] out_x,
   output logic signed [R_W-1:0] out_y,
   output logic signed [Z_W-1:0] out_z,
   output logic [SW-1:0]         out_side
);

   logic signed [R_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic [SW-1:0]         side_ff;

   // Rotate toward the sign of the residual angle.
   always_comb begin
      if (in_z >= 0) begin
         x_in = in_x - (in_y >>> SHIFT);
         y_in = in_y + (in_x >>> SHIFT);
         z_in = in_z - ATAN_Q24[SHIFT];
      end else begin
         x_in = in_x + (in_y >>> SHIFT);
         y_in = in_y - (in_x >>> SHIFT);
         z_in = in_z + ATAN_Q24[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule

FILE: design/scp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider cell
// Decides quotient bit J by one compare and subtract of the shifted divisor.
// ----------------------------------------------------------------------------
module scp_div_cell
   import scp_pkg::*;
#(
   parameter int RW = 40,
   parameter int DW = 38,
   parameter int J  = 15,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            en,
   input  logic [RW-1:0]   in_r,
   input  logic [DW-1:0]   in_d,
   input  logic [Q_W-1:0]  in_q,
   input  logic [SW-1:0]   in_side,
   output logic [RW-1:0]   out_r,
   output logic [DW-1:0]   out_d,
   output logic [Q_W-1:0]  out_q,
   output logic [SW-1:0]   out_side
);

   localparam int CW = (RW > DW + J + 1) ? RW : DW + J + 1;

   logic [CW-1:0]  trial;
   logic           fits;
   logic [RW-1:0]  r_ff, r_in;
   logic [DW-1:0]  d_ff;
   logic [Q_W-1:0] q_ff, q_in;
   logic [SW-1:0]  side_ff;

   // Subtract the divisor at weight 2^J when it fits.
   always_comb begin
      trial = CW'(in_d) << J;
      fits  = CW'(in_r) >= trial;
      r_in  = fits ? RW'(CW'(in_r) - trial) : in_r;
      q_in  = in_q | (Q_W'(fits) << J);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         d_ff    <= in_d;
         q_ff    <= q_in;
         side_ff <= in_side;
      end
   end

   assign out_r    = r_ff;
   assign out_d    = d_ff;
   assign out_q    = q_ff;
   assign out_side = side_ff;

endmodule

FILE: design/sprite_camera_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite camera projection
// Tests one sprite against the camera and projects it onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_* carries sprite and eye position (Q16.16) and the look
//   direction (Q2.14). Each request yields exactly one response on rsp_*:
//   rsp_tuser is the visible flag, rsp_tdata holds anchor_x, anchor_y and
//   scale, all zero for a sprite that is not seen.
//   Registers are written on csr_* (always ready) while no request is in
//   flight.
//   Throughput: one request per cycle while the output queue has room. A
//   request passes through two CORDIC chains of CORDIC_STAGES cells, the
//   16-cell divider chains and the fixed stages around them.
//   The whole pipeline advances together. A two-entry output queue lets a
//   response wait while new requests are taken; only when both entries are
//   full does req_tready drop and the pipeline hold.
//   Reset is synchronous; it empties the pipeline and the queue and loads the
//   register reset values.
// ----------------------------------------------------------------------------
module sprite_camera_projection
   import scp_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int POS_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Fields from bit 0: sprite_x, sprite_y, eye_x, eye_y, look_x, look_y.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   // Fields from bit 0: anchor_x, anchor_y, scale.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   // Fields from bit 0: visible.
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int N    = CORDIC_STAGES;
   localparam int F    = POS_FRAC_BITS;
   localparam int LAT  = 2 * N + 28;
   localparam int SC_W = 20 + F;
   localparam int T1_W = DIST_W + 11;
   localparam int NUM_W = ((T1_W + 1) > (33 + F) ? (T1_W + 1) : (33 + F)) + 1;
   localparam int CS_W = (SC_W > DIST_W + 16) ? SC_W : DIST_W + 16;
   localparam int AY_W = (NUM_W > DIST_W + 16) ? NUM_W : DIST_W + 16;
   localparam int AX_W = 28;
   localparam int RS_W = $bits(rot_side_type);

   // Configuration registers.
   logic [14:0]        fov_ff;
   logic [11:0]        pw_ff;
   logic [15:0]        pd_ff;
   logic signed [15:0] ch_ff;
   logic [11:0]        sh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff <= 15'd8579;
         pw_ff  <= 12'd640;
         pd_ff  <= 16'd554;
         ch_ff  <= 16'sd32;
         sh_ff  <= 12'd480;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOV: fov_ff <= csr_data[14:0];
            CSR_PW:  pw_ff  <= csr_data[11:0];
            CSR_PD:  pd_ff  <= csr_data;
            CSR_CH:  ch_ff  <= $signed(csr_data);
            CSR_SH:  sh_ff  <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance and valid line.
   logic       adv;
   logic       push, pop;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       vld_ff [0:LAT-1];

   assign adv        = (q_cnt_ff != 2'd2);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage S0: offsets from eye to sprite.
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [15:0] lx_ff, ly_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= $signed({req_tdata[31], req_tdata[31:0]})
                - $signed({req_tdata[95], req_tdata[95:64]});
         dy_ff <= $signed({req_tdata[63], req_tdata[63:32]})
                - $signed({req_tdata[127], req_tdata[127:96]});
         lx_ff <= $signed(req_tdata[143:128]);
         ly_ff <= $signed(req_tdata[159:144]);
      end
   end

   // Stage S1: scale and fold both vectors into the right half plane.
   logic signed [VS_W-1:0] sx_raw, sy_raw, sx1_ff, sy1_ff;
   logic signed [VC_W-1:0] cx_raw, cy_raw, cx1_ff, cy1_ff;
   logic signed [Z_W-1:0]  sz1_ff, cz1_ff;
   logic                   zs1_ff, zc1_ff;

   assign sx_raw = VS_W'($signed({dy_ff, 8'd0}));
   assign sy_raw = VS_W'($signed({dx_ff, 8'd0}));
   assign cx_raw = VC_W'($signed({ly_ff, 16'd0}));
   assign cy_raw = VC_W'($signed({lx_ff, 16'd0}));

   always_ff @(posedge clock) begin
      if (adv) begin
         zs1_ff <= (dx_ff == '0) && (dy_ff == '0);
         zc1_ff <= (lx_ff == '0) && (ly_ff == '0);
         if (sx_raw < 0) begin
            sx1_ff <= -sx_raw;
            sy1_ff <= -sy_raw;
            sz1_ff <= (sy_raw >= 0) ? PI_Q24 : -PI_Q24;
         end else begin
            sx1_ff <= sx_raw;
            sy1_ff <= sy_raw;
            sz1_ff <= '0;
         end
         if (cx_raw < 0) begin
            cx1_ff <= -cx_raw;
            cy1_ff <= -cy_raw;
            cz1_ff <= (cy_raw >= 0) ? PI_Q24 : -PI_Q24;
         end else begin
            cx1_ff <= cx_raw;
            cy1_ff <= cy_raw;
            cz1_ff <= '0;
         end
      end
   end

   // Vectoring chains for the sprite offset and the look direction.
   logic signed [VS_W-1:0] vs_x [0:N];
   logic signed [VS_W-1:0] vs_y [0:N];
   logic signed [Z_W-1:0]  vs_z [0:N];
   logic                   vs_s [0:N];
   logic signed [VC_W-1:0] vc_x [0:N];
   logic signed [VC_W-1:0] vc_y [0:N];
   logic signed [Z_W-1:0]  vc_z [0:N];
   logic                   vc_s [0:N];

   assign vs_x[0] = sx1_ff;
   assign vs_y[0] = sy1_ff;
   assign vs_z[0] = sz1_ff;
   assign vs_s[0] = zs1_ff;
   assign vc_x[0] = cx1_ff;
   assign vc_y[0] = cy1_ff;
   assign vc_z[0] = cz1_ff;
   assign vc_s[0] = zc1_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec
      scp_vec_cell #(.W(VS_W), .SHIFT(k), .SW(1)) u_sprite (
         .clock(clock), .en(adv),
         .in_x(vs_x[k]), .in_y(vs_y[k]), .in_z(vs_z[k]), .in_side(vs_s[k]),
         .out_x(vs_x[k+1]), .out_y(vs_y[k+1]), .out_z(vs_z[k+1]),
         .out_side(vs_s[k+1])
      );
      scp_vec_cell #(.W(VC_W), .SHIFT(k), .SW(1)) u_camera (
         .clock(clock), .en(adv),
         .in_x(vc_x[k]), .in_y(vc_y[k]), .in_z(vc_z[k]), .in_side(vc_s[k]),
         .out_x(vc_x[k+1]), .out_y(vc_y[k+1]), .out_z(vc_z[k+1]),
         .out_side(vc_s[k+1])
      );
   end

   // Stage P1: clamp and round headings to Q13, gain-correct the magnitude.
   logic signed [Z_W-1:0] hs_cl, hc_cl, hs_rnd, hc_rnd;
   logic signed [15:0]    hs13_ff, hc13_ff;
   logic [VS_W+14:0]      mprod_ff;

   assign hs_cl  = (vs_z[N] > PI_Q24) ? PI_Q24 :
                   ((vs_z[N] < -PI_Q24) ? -PI_Q24 : vs_z[N]);
   assign hc_cl  = (vc_z[N] > PI_Q24) ? PI_Q24 :
                   ((vc_z[N] < -PI_Q24) ? -PI_Q24 : vc_z[N]);
   assign hs_rnd = (hs_cl + RND_Q24) >>> 11;
   assign hc_rnd = (hc_cl + RND_Q24) >>> 11;

   always_ff @(posedge clock) begin
      if (adv) begin
         hs13_ff  <= vs_s[N] ? 16'sd0 : hs_rnd[15:0];
         hc13_ff  <= vc_s[N] ? 16'sd0 : hc_rnd[15:0];
         mprod_ff <= vs_x[N][VS_W-2:0] * GAIN_Q16;
      end
   end

   // Stage P2: relative angle, wrapped once into [-pi, pi].
   logic signed [16:0]    ang_raw, ang_wrap;
   logic signed [15:0]    ang2_ff;
   logic [MAG_W-1:0]      mag2_ff;

   assign ang_raw = $signed({hc13_ff[15], hc13_ff}) - $signed({hs13_ff[15], hs13_ff});

   always_comb begin
      if (ang_raw > PI_Q13) begin
         ang_wrap = ang_raw - TWO_PI_Q13;
      end else if (ang_raw < -PI_Q13) begin
         ang_wrap = ang_raw + TWO_PI_Q13;
      end else begin
         ang_wrap = ang_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang2_ff <= ang_wrap[15:0];
         mag2_ff <= mprod_ff[VS_W+14:24];
      end
   end

   // Stage P3: field of view test and the cosine argument.
   logic [15:0]           absa, a13;
   logic                  neg3;
   rot_side_type          p3_side_in, p3_side_ff;
   logic signed [Z_W-1:0] a24_ff;

   assign absa = ang2_ff[15] ? 16'(-ang2_ff) : ang2_ff;
   assign neg3 = $signed({1'b0, absa}) > HALF_PI_Q13;
   assign a13  = neg3 ? (PI_Q13[15:0] - absa) : absa;

   always_comb begin
      p3_side_in.vis = {absa, 1'b0} <= {2'b00, fov_ff};
      p3_side_in.neg = neg3;
      p3_side_in.ang = ang2_ff;
      p3_side_in.mag = mag2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_side_ff <= p3_side_in;
         a24_ff     <= $signed(Z_W'({a13, 11'd0}));
      end
   end

   // Rotating chain for the cosine.
   logic signed [R_W-1:0] rc_x [0:N];
   logic signed [R_W-1:0] rc_y [0:N];
   logic signed [Z_W-1:0] rc_z [0:N];
   logic [RS_W-1:0]       rc_s [0:N];

   assign rc_x[0] = GAIN_Q24;
   assign rc_y[0] = '0;
   assign rc_z[0] = a24_ff;
   assign rc_s[0] = p3_side_ff;

   for (genvar k = 0; k < N; k++) begin : g_rot
      scp_rot_cell #(.SHIFT(k), .SW(RS_W)) u_cos (
         .clock(clock), .en(adv),
         .in_x(rc_x[k]), .in_y(rc_y[k]), .in_z(rc_z[k]), .in_side(rc_s[k]),
         .out_x(rc_x[k+1]), .out_y(rc_y[k+1]), .out_z(rc_z[k+1]),
         .out_side(rc_s[k+1])
      );
   end

   // Stage P4: sign of the cosine for angles past a quarter turn.
   rot_side_type          rot_out, p4_side_ff;
   logic signed [R_W-1:0] c_ff;

   assign rot_out = rc_s[N];

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff       <= rot_out.neg ? -rc_x[N] : rc_x[N];
         p4_side_ff <= rot_out;
      end
   end

   // Stage P5: perpendicular distance product.
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [15:0]       ang5_ff;
   logic                     vis5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= $signed({1'b0, p4_side_ff.mag}) * c_ff;
         ang5_ff <= p4_side_ff.ang;
         vis5_ff <= p4_side_ff.vis;
      end
   end

   // Stage P6: distance and final visibility.
   logic                dpos;
   logic [DIST_W-1:0]   dist6_ff;
   logic signed [15:0]  ang6_ff;
   logic                vis6_ff;

   assign dpos = !prod_ff[PROD_W-1] && (prod_ff[PROD_W-1:24] != '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         dist6_ff <= prod_ff[24+DIST_W-1:24];
         ang6_ff  <= ang5_ff;
         vis6_ff  <= vis5_ff && dpos;
      end
   end

   // Stage P7: partial products for the vertical and horizontal anchors.
   logic [17:0]         axn_wide;
   logic [T1_W-1:0]     t1_ff;
   logic signed [32:0]  pdch_ff;
   logic [15:0]         axn_ff;
   logic [DIST_W-1:0]   dist7_ff;
   logic                vis7_ff;

   assign axn_wide = {ang6_ff[15], ang6_ff, 1'b0} + {3'b000, fov_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff    <= sh_ff[11:1] * dist6_ff;
         pdch_ff  <= $signed({1'b0, pd_ff}) * ch_ff;
         axn_ff   <= axn_wide[15:0];
         dist7_ff <= dist6_ff;
         vis7_ff  <= vis6_ff;
      end
   end

   // Stage P8: vertical numerator and horizontal numerator.
   logic signed [NUM_W-1:0] num_ff;
   logic [AX_W-1:0]         axp_ff;
   logic [DIST_W-1:0]       dist8_ff;
   logic                    vis8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff   <= NUM_W'($signed({1'b0, t1_ff})) + (NUM_W'(pdch_ff) <<< F);
         axp_ff   <= axn_ff * pw_ff;
         dist8_ff <= dist7_ff;
         vis8_ff  <= vis7_ff;
      end
   end

   // Stage P9: magnitude of the vertical numerator, scale overflow check.
   logic [SC_W-1:0]    sc_div;
   logic [NUM_W-1:0]   anum9_ff;
   logic               ngt9_ff, satsc9_ff, vis9_ff;
   logic [AX_W-1:0]    axp9_ff;
   logic [DIST_W-1:0]  dist9_ff;

   assign sc_div = {sh_ff, {(8 + F){1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         anum9_ff  <= num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
         ngt9_ff   <= num_ff[NUM_W-1];
         satsc9_ff <= CS_W'(sc_div) >= CS_W'({dist8_ff, 16'd0});
         axp9_ff   <= axp_ff;
         dist9_ff  <= dist8_ff;
         vis9_ff   <= vis8_ff;
      end
   end

   // Stage P10: vertical overflow check, divider operands.
   logic [NUM_W-1:0]   anum10_ff;
   logic               ngt10_ff, satsc10_ff, satay10_ff, vis10_ff;
   logic [AX_W-1:0]    axp10_ff;
   logic [DIST_W-1:0]  dist10_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         anum10_ff  <= anum9_ff;
         ngt10_ff   <= ngt9_ff;
         satsc10_ff <= satsc9_ff;
         satay10_ff <= AY_W'(anum9_ff) >= AY_W'({dist9_ff, 16'd0});
         axp10_ff   <= axp9_ff;
         dist10_ff  <= dist9_ff;
         vis10_ff   <= vis9_ff;
      end
   end

   // Divider chains: scale, horizontal anchor and vertical anchor.
   logic [SC_W-1:0]   dsc_r [0:Q_W];
   logic [DIST_W-1:0] dsc_d [0:Q_W];
   logic [Q_W-1:0]    dsc_q [0:Q_W];
   logic              dsc_s [0:Q_W];
   logic [AX_W-1:0]   dax_r [0:Q_W];
   logic [15:0]       dax_d [0:Q_W];
   logic [Q_W-1:0]    dax_q [0:Q_W];
   logic [1:0]        dax_s [0:Q_W];
   logic [NUM_W-1:0]  day_r [0:Q_W];
   logic [DIST_W-1:0] day_d [0:Q_W];
   logic [Q_W-1:0]    day_q [0:Q_W];
   logic [1:0]        day_s [0:Q_W];

   assign dsc_r[0] = sc_div;
   assign dsc_d[0] = dist10_ff;
   assign dsc_q[0] = '0;
   assign dsc_s[0] = satsc10_ff;
   assign dax_r[0] = axp10_ff;
   assign dax_d[0] = {fov_ff, 1'b0};
   assign dax_q[0] = '0;
   assign dax_s[0] = {vis10_ff, (fov_ff == '0)};
   assign day_r[0] = anum10_ff;
   assign day_d[0] = dist10_ff;
   assign day_q[0] = '0;
   assign day_s[0] = {satay10_ff, ngt10_ff};

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      scp_div_cell #(.RW(SC_W), .DW(DIST_W), .J(Q_W - 1 - k), .SW(1)) u_sc (
         .clock(clock), .en(adv),
         .in_r(dsc_r[k]), .in_d(dsc_d[k]), .in_q(dsc_q[k]), .in_side(dsc_s[k]),
         .out_r(dsc_r[k+1]), .out_d(dsc_d[k+1]), .out_q(dsc_q[k+1]),
         .out_side(dsc_s[k+1])
      );
      scp_div_cell #(.RW(AX_W), .DW(16), .J(Q_W - 1 - k), .SW(2)) u_ax (
         .clock(clock), .en(adv),
         .in_r(dax_r[k]), .in_d(dax_d[k]), .in_q(dax_q[k]), .in_side(dax_s[k]),
         .out_r(dax_r[k+1]), .out_d(dax_d[k+1]), .out_q(dax_q[k+1]),
         .out_side(dax_s[k+1])
      );
      scp_div_cell #(.RW(NUM_W), .DW(DIST_W), .J(Q_W - 1 - k), .SW(2)) u_ay (
         .clock(clock), .en(adv),
         .in_r(day_r[k]), .in_d(day_d[k]), .in_q(day_q[k]), .in_side(day_s[k]),
         .out_r(day_r[k+1]), .out_d(day_d[k+1]), .out_q(day_q[k+1]),
         .out_side(day_s[k+1])
      );
   end

   // Final formatting with saturation; hidden sprites report zeros.
   rsp_type res_in;
   logic    fin_vis, fin_fov0, fin_satay, fin_ngt, ay_big;

   assign fin_vis   = dax_s[Q_W][1];
   assign fin_fov0  = dax_s[Q_W][0];
   assign fin_satay = day_s[Q_W][1];
   assign fin_ngt   = day_s[Q_W][0];
   assign ay_big    = fin_satay ||
                      (fin_ngt ? (day_q[Q_W] > 16'd32768) : (day_q[Q_W] > 16'd32767));

   always_comb begin
      res_in.visible  = fin_vis;
      res_in.anchor_x = '0;
      res_in.anchor_y = '0;
      res_in.scale    = '0;
      if (fin_vis) begin
         res_in.anchor_x = fin_fov0 ? 16'd0 : dax_q[Q_W];
         res_in.scale    = dsc_s[Q_W] ? 16'hFFFF : dsc_q[Q_W];
         if (ay_big) begin
            res_in.anchor_y = fin_ngt ? 16'h8000 : 16'h7FFF;
         end else begin
            res_in.anchor_y = fin_ngt ? 16'(-day_q[Q_W]) : day_q[Q_W];
         end
      end
   end

   // Two-entry output queue.
   rsp_type out_q_ff [0:1];
   logic    wr_ptr_ff, rd_ptr_ff;

   assign push     = adv && vld_ff[LAT-1];
   assign pop      = rsp_tvalid && rsp_tready;
   assign q_cnt_in = q_cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_q_ff[wr_ptr_ff] <= res_in;
      end
   end

   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_tuser  = out_q_ff[rd_ptr_ff].visible;
   assign rsp_tdata  = {out_q_ff[rd_ptr_ff].scale, out_q_ff[rd_ptr_ff].anchor_y,
                        out_q_ff[rd_ptr_ff].anchor_x};

   // The queue never holds more than two responses.
   assert property (@(posedge clock) disable iff (reset) q_cnt_ff != 2'd3)
      else $error("output queue count out of range");

   // A hidden sprite reports all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("hidden sprite with nonzero fields");

   // A visible anchor_x lies between zero and the plane width.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[15:0] <= {4'b0000, pw_ff}))
      else $error("anchor_x outside the projection plane");

endmodule

FILE: sim/sprite_camera_projection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite camera projection testbench
// Drives sprite and camera requests through the projection block under
// several register settings and checks every response, field by field,
// against a fixed-point predictor kept inside this bench.
// ----------------------------------------------------------------------------
module sprite_camera_projection_tb
   import scp_pkg::*;
;

   localparam int N_STAGES = 16;
   localparam int FRAC = 16;
   localparam int LATENCY = 2 * N_STAGES + 28;
   localparam int RANDOM_ITEMS = 680;

   localparam longint PI24 = 52707179;
   localparam longint PI13 = 25736;
   localparam longint TWO_PI13 = 51472;
   localparam longint HALF_PI13 = 12868;
   localparam longint GAIN16 = 39797;
   localparam longint GAIN24 = 10187176;
   localparam longint ARCTAN [0:23] = '{
      13176795, 7778716, 4110060, 2086331, 1047215, 524117, 262124, 131070,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic signed [15:0] look_y;
      logic signed [15:0] look_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_x;
      logic signed [31:0] sprite_y;
      logic signed [31:0] sprite_x;
   } sprite_req_type;

   typedef struct packed {
      logic        visible;
      logic [15:0] scale;
      logic [15:0] anchor_y;
      logic [15:0] anchor_x;
   } projection_type;

   typedef struct {
      sprite_req_type req;
      logic           known;
      projection_type want;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   // Camera registers as the predictor sees them.
   longint fov_r, pw_r, pd_r, ch_r, sh_r;

   projection_type pending_projections[$];
   int mismatch_count = 0;
   int hold_cycles = 0;
   bit stimulus_done = 1'b0;

   sprite_camera_projection dut (.*);

   always #10 clock = ~clock;

   // Arithmetic shift right with floor rounding for negative values.
   function automatic longint asr(longint v, int n);
      return v >>> n;
   endfunction

   // Vectoring pass: heading atan2(yy, xx) in Q24 and the corrected magnitude.
   function automatic void vector_heading(input longint xx, input longint yy,
                                          output longint ang, output longint mag);
      longint x, y, z, t;
      x = xx;
      y = yy;
      z = 0;
      if (x == 0 && y == 0) begin
         ang = 0;
         mag = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? PI24 : -PI24;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < N_STAGES; i++) begin
         t = x;
         if (y < 0) begin
            x -= asr(y, i);
            y += asr(t, i);
            z -= ARCTAN[i];
         end else begin
            x += asr(y, i);
            y -= asr(t, i);
            z += ARCTAN[i];
         end
      end
      if (z > PI24) z = PI24;
      if (z < -PI24) z = -PI24;
      ang = z;
      mag = (x * GAIN16) >>> 16;
   endfunction

   // Rotating pass: cosine in Q24 of an angle in [0, pi/2].
   function automatic longint rotate_cosine(longint a);
      longint x, y, z, t;
      x = GAIN24;
      y = 0;
      z = a;
      for (int i = 0; i < N_STAGES; i++) begin
         t = x;
         if (z >= 0) begin
            x -= asr(y, i);
            y += asr(t, i);
            z -= ARCTAN[i];
         end else begin
            x += asr(y, i);
            y -= asr(t, i);
            z += ARCTAN[i];
         end
      end
      return x;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Projects one sprite the way the block should.
   function automatic projection_type project_sprite(sprite_req_type r);
      projection_type p;
      longint dx, dy, hs, hc, mag, unused, ang, absa, c, perp_dist, sc, ax, num;
      bit neg;
      p = '0;
      dx = longint'(r.sprite_x) - longint'(r.eye_x);
      dy = longint'(r.sprite_y) - longint'(r.eye_y);
      vector_heading(dy * 256, dx * 256, hs, mag);
      mag = mag >>> 8;
      vector_heading(longint'(r.look_y) * 65536, longint'(r.look_x) * 65536, hc, unused);
      ang = asr(hc + 1024, 11) - asr(hs + 1024, 11);
      if (ang > PI13 || ang < -PI13)
         ang = (ang > 0) ? ang - TWO_PI13 : ang + TWO_PI13;
      absa = (ang < 0) ? -ang : ang;
      if (2 * absa > fov_r) return p;
      neg = absa > HALF_PI13;
      c = rotate_cosine((neg ? PI13 - absa : absa) * 2048);
      if (neg) c = -c;
      perp_dist = asr(mag * c, 24);
      if (perp_dist <= 0) return p;
      sc = (sh_r << (8 + FRAC)) / perp_dist;
      if (sc > 65535) sc = 65535;
      ax = (fov_r == 0) ? 0 : ((2 * ang + fov_r) * pw_r) / (2 * fov_r);
      num = (sh_r >> 1) * perp_dist + pd_r * ch_r * (longint'(1) << FRAC);
      p.visible = 1'b1;
      p.anchor_x = 16'(clamp16(ax));
      p.anchor_y = 16'(clamp16(num / perp_dist));
      p.scale = 16'(sc);
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic wait_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   // Writes one register between phases and mirrors it in the predictor.
   task automatic write_register(input logic [2:0] idx, input longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FOV: fov_r = value & 16'h7FFF;
         CSR_PW:  pw_r = value & 12'hFFF;
         CSR_PD:  pd_r = value & 16'hFFFF;
         CSR_CH:  ch_r = longint'(signed'(16'(value)));
         CSR_SH:  sh_r = value & 12'hFFF;
         default: ;
      endcase
   endtask

   // Offers one request after a random gap and waits until it is taken.
   // The request line stays high into the next call when no gap is drawn.
   task automatic send_request(input sprite_req_type r, input bit known,
                               input projection_type want);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         wait_cycles(gap);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      do @(posedge clock); while (!req_tready);
      pending_projections.push_back(known ? want : project_sprite(r));
      @(negedge clock);
   endtask

   task automatic drain_pipeline;
      req_tvalid <= 1'b0;
      while (pending_projections.size() != 0) @(negedge clock);
      wait_cycles(LATENCY + 10);
   endtask

   function automatic sprite_req_type random_request;
      sprite_req_type r;
      int mode;
      mode = $urandom_range(0, 9);
      r.eye_x = $urandom;
      r.eye_y = $urandom;
      r.look_x = $urandom;
      r.look_y = $urandom;
      if (mode < 7) begin
         // Sprite near the camera, ahead of it most of the time.
         r.sprite_x = r.eye_x + 32'(signed'($urandom_range(0, 2 ** 24)) - 2 ** 23)
                      + 32'(longint'(r.look_x) * $urandom_range(0, 2 ** 10));
         r.sprite_y = r.eye_y + 32'(signed'($urandom_range(0, 2 ** 24)) - 2 ** 23)
                      + 32'(longint'(r.look_y) * $urandom_range(0, 2 ** 10));
      end else begin
         r.sprite_x = $urandom;
         r.sprite_y = $urandom;
      end
      return r;
   endfunction

   function automatic sprite_req_type make_req(longint sx, longint sy, longint ex, longint ey,
                                               longint lx, longint ly);
      sprite_req_type r;
      r.sprite_x = 32'(sx);
      r.sprite_y = 32'(sy);
      r.eye_x = 32'(ex);
      r.eye_y = 32'(ey);
      r.look_x = 16'(lx);
      r.look_y = 16'(ly);
      return r;
   endfunction

   // Response checker: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_projections.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_projections.pop_front();
            if (rsp_tuser !== want.visible)
               report_mismatch("visible", rsp_tuser, want.visible);
            if (rsp_tdata[15:0] !== want.anchor_x)
               report_mismatch("anchor_x", signed'(rsp_tdata[15:0]), signed'(want.anchor_x));
            if (rsp_tdata[31:16] !== want.anchor_y)
               report_mismatch("anchor_y", signed'(rsp_tdata[31:16]), signed'(want.anchor_y));
            if (rsp_tdata[47:32] !== want.scale)
               report_mismatch("scale", rsp_tdata[47:32], want.scale);
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off during the random phase.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (stimulus_done) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      directed_row_type rows[$];
      projection_type none;
      sprite_req_type r;
      int settings [0:3][0:4];
      none = '0;
      fov_r = 8579;
      pw_r = 640;
      pd_r = 554;
      ch_r = 32;
      sh_r = 480;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: zero vectors, extremes, behind, edges of view.
      rows.push_back('{make_req(0, 0, 0, 0, 0, 0), 1'b0, none});
      rows.push_back('{make_req(0, 10 << 16, 0, 0, 0, 16384), 1'b0, none});
      rows.push_back('{make_req(0, -(10 << 16), 0, 0, 0, 16384), 1'b1, none});
      rows.push_back('{make_req(10 << 16, 0, 0, 0, 16384, 0), 1'b0, none});
      rows.push_back('{make_req(-(10 << 16), 0, 0, 0, 16384, 0), 1'b1, none});
      rows.push_back('{make_req(0, 1, 0, 0, 0, 16384), 1'b0, none});
      rows.push_back('{make_req(0, 2 ** 31 - 1, 0, -(2 ** 31), 0, 32767), 1'b0, none});
      rows.push_back('{make_req(-(2 ** 31), -(2 ** 31), 2 ** 31 - 1, 2 ** 31 - 1,
                                -32768, -32768), 1'b0, none});
      rows.push_back('{make_req(2 ** 31 - 1, 0, -(2 ** 31), 0, 32767, 0), 1'b0, none});
      rows.push_back('{make_req(5 << 16, 5 << 16, 0, 0, 0, 16384), 1'b0, none});
      rows.push_back('{make_req(3 << 16, 10 << 16, 0, 0, 0, 16384), 1'b0, none});
      rows.push_back('{make_req(-(3 << 16), 10 << 16, 0, 0, 0, 16384), 1'b0, none});
      rows.push_back('{make_req(0, 100, 0, 0, -1, 16384), 1'b0, none});
      rows.push_back('{make_req(0, 10 << 16, 0, 0, 0, 0), 1'b0, none});
      rows.push_back('{make_req(-(10 << 16), 1, 0, 0, -16384, 0), 1'b0, none});
      rows.push_back('{make_req(-(10 << 16), -1, 0, 0, -16384, 0), 1'b0, none});
      rows.push_back('{make_req(0, 8, 0, 0, 0, 16384), 1'b0, none});
      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].want);
      drain_pipeline();

      // Register settings: wide view with maxima, small values, all zeros, then reset values.
      settings = '{'{25736, 4095, 65535, -32768, 4095},
                   '{1, 1, 1, 32767, 1},
                   '{0, 0, 0, 0, 0},
                   '{8579, 640, 554, 32, 480}};
      for (int phase = 0; phase < 4; phase++) begin
         write_register(CSR_FOV, settings[phase][0]);
         write_register(CSR_PW, settings[phase][1]);
         write_register(CSR_PD, settings[phase][2]);
         write_register(CSR_CH, settings[phase][3]);
         write_register(CSR_SH, settings[phase][4]);
         if (phase == 2) begin
            // Field of view zero: only a dead-ahead sprite is seen.
            write_register(CSR_FOV, 0);
            write_register(CSR_PW, 320);
            write_register(CSR_PD, 200);
            write_register(CSR_SH, 240);
            write_register(3'd7, 16'hFFFF);
            send_request(make_req(0, 10 << 16, 0, 0, 0, 16384), 1'b0, none);
            send_request(make_req(1 << 16, 10 << 16, 0, 0, 0, 16384), 1'b1, none);
            drain_pipeline();
            write_register(CSR_FOV, $urandom_range(1, 25736));
         end
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            if (phase == 1 && n == 20) hold_cycles = 200;
            r = random_request();
            send_request(r, 1'b0, none);
         end
         drain_pipeline();
      end

      stimulus_done = 1'b1;
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
